// ===== rtl/qwp_pkg.sv =====
`timescale 1ns / 1ps
package qwp_pkg;

  localparam int SIZE_W     = 32;
  localparam int COUNT_W    = 7;
  localparam int IDX_W      = 6;
  localparam int PART_LIMIT = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int DIV_STEPS  = SIZE_W;
  localparam int DIV_CNT_W  = 6;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_PARTS        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREFERRED_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUANTUM          = 2'd2;

  localparam logic [COUNT_W-1:0] MAX_PARTS_RST  = 7'd16;
  localparam logic [SIZE_W-1:0]  PREF_LEN_RST   = 32'd4096;
  localparam logic [SIZE_W-1:0]  QUANTUM_RST    = 32'd16;

  // one job as handed from the front part to the chunk emitter
  typedef struct packed {
    logic [SIZE_W-1:0]  total;
    logic [COUNT_W-1:0] count;
    logic [SIZE_W-1:0]  part;
    logic [SIZE_W-1:0]  quantum;
    logic [COUNT_W-1:0] extra;
  } job_desc_t;

  function automatic logic [COUNT_W-1:0] eff_limit(input logic [COUNT_W-1:0] mp);
    logic [COUNT_W-1:0] r;
    r = mp;
    if (mp == '0) r = COUNT_W'(1);
    else if (mp > COUNT_W'(PART_LIMIT)) r = COUNT_W'(PART_LIMIT);
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] eff_quantum(input logic [SIZE_W-1:0] q);
    return (q == '0) ? SIZE_W'(1) : q;
  endfunction

endpackage

// ===== rtl/quantized_work_partitioner_core.sv =====
`timescale 1ns / 1ps
// Splits each total_length transaction into up to 64 contiguous chunks and
// returns them in order as (chunk_start, chunk_length, final_chunk), the last
// one flagged. A front part accepts a job and works out chunk count, quantized
// base length and the number of longer chunks on one shared radix-2 divider;
// a two-entry job queue then feeds the emitter, which delivers one chunk per
// cycle unless out_stall holds it, and the front part already works on the
// next job. A job that splits takes four divisions plus three steps in the
// front part, or three divisions when preferred_length is zero and the count
// division is skipped; a single-chunk job takes none. So the sustained rate
// is set by the divider, or by the chunk count when the output side
// is slower. Configuration (index 0 max_parts, 1 preferred_length, 2 quantum)
// is taken at any time but must only change while no job is in flight; other
// indexes are ignored.
module quantized_work_partitioner_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [qwp_pkg::SIZE_W-1:0]   in_total_length,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [qwp_pkg::SIZE_W-1:0]   out_chunk_start,
  output logic [qwp_pkg::SIZE_W-1:0]   out_chunk_length,
  output logic                         out_final_chunk,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [qwp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qwp_pkg::SIZE_W-1:0]   cfg_data
);
  import qwp_pkg::*;

  logic [COUNT_W-1:0] max_parts_r;
  logic [SIZE_W-1:0]  pref_r;
  logic [SIZE_W-1:0]  quantum_r;

  logic               push, q_full, pop, q_empty;
  job_desc_t          push_desc, pop_desc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_parts_r <= MAX_PARTS_RST;
      pref_r      <= PREF_LEN_RST;
      quantum_r   <= QUANTUM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_PARTS:        max_parts_r <= cfg_data[COUNT_W-1:0];
        REG_PREFERRED_LENGTH: pref_r      <= cfg_data;
        REG_QUANTUM:          quantum_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  qwp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_total_length (in_total_length),
    .limit           (eff_limit(max_parts_r)),
    .pref            (pref_r),
    .q_eff           (eff_quantum(quantum_r)),
    .push            (push),
    .push_desc       (push_desc),
    .q_full          (q_full)
  );

  qwp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (pop),
    .pop_desc  (pop_desc),
    .empty     (q_empty)
  );

  qwp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .desc             (pop_desc),
    .q_empty          (q_empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_chunk_start  (out_chunk_start),
    .out_chunk_length (out_chunk_length),
    .out_final_chunk  (out_final_chunk)
  );
endmodule

// ===== rtl/qwp_div.sv =====
`timescale 1ns / 1ps
module qwp_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [qwp_pkg::SIZE_W-1:0] dividend,
  input  logic [qwp_pkg::SIZE_W-1:0] divisor,
  output logic                      done,
  output logic [qwp_pkg::SIZE_W-1:0] quotient
);
  import qwp_pkg::*;

  logic [SIZE_W-1:0]    rem_r;
  logic [SIZE_W-1:0]    quo_r;
  logic [SIZE_W-1:0]    dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [SIZE_W:0]      shifted;
  logic [SIZE_W:0]      diff;
  logic                 ge;

  // restoring division, one quotient bit a cycle
  assign shifted = {rem_r, quo_r[SIZE_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = ~diff[SIZE_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= '0;
        quo_r <= dividend;
        dvs_r <= divisor;
        cnt_r <= DIV_CNT_W'(DIV_STEPS);
      end else if (cnt_r != '0) begin
        rem_r <= ge ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
        quo_r <= {quo_r[SIZE_W-2:0], ge};
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) done_r <= 1'b1;
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (cnt_r == '0)) else $error("divider restarted while busy");
endmodule

// ===== rtl/qwp_front.sv =====
`timescale 1ns / 1ps
module qwp_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [qwp_pkg::SIZE_W-1:0]  in_total_length,
  input  logic [qwp_pkg::COUNT_W-1:0] limit,
  input  logic [qwp_pkg::SIZE_W-1:0]  pref,
  input  logic [qwp_pkg::SIZE_W-1:0]  q_eff,
  output logic                        push,
  output qwp_pkg::job_desc_t          push_desc,
  input  logic                        q_full
);
  import qwp_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV1 = 3'd1;
  localparam logic [2:0] ST_DIV2 = 3'd2;
  localparam logic [2:0] ST_DIV3 = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_SUB  = 3'd5;
  localparam logic [2:0] ST_DIV4 = 3'd6;
  localparam logic [2:0] ST_PUSH = 3'd7;

  logic [2:0]          state_r, state_nxt;
  logic [SIZE_W-1:0]   total_r;
  logic [COUNT_W-1:0]  count_r;
  logic [SIZE_W-1:0]   part_r;
  logic [SIZE_W-1:0]   cp_r;
  logic [COUNT_W-1:0]  extra_r;

  logic                div_start;
  logic [SIZE_W-1:0]   div_a, div_b;
  logic                div_done;
  logic [SIZE_W-1:0]   quot;
  logic                accept;
  logic                single;
  logic [COUNT_W-1:0]  count_nxt;
  logic [2*SIZE_W-1:0] part_prod;
  logic [SIZE_W+COUNT_W-1:0] cp_prod;

  qwp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (quot)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);
  // total below twice the preferred length gives a single chunk
  assign single   = ((in_total_length >> 1) < pref);

  always_comb begin
    count_nxt = quot[COUNT_W-1:0];
    if (quot > {{(SIZE_W-COUNT_W){1'b0}}, limit}) count_nxt = limit;
    else if (quot == '0) count_nxt = COUNT_W'(1);
  end

  assign part_prod = quot * q_eff;
  assign cp_prod   = count_r * part_r;

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_a     = total_r;
    div_b     = q_eff;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && !single) begin
          div_start = 1'b1;
          div_a     = in_total_length;
          if (pref == '0) begin
            div_b     = {{(SIZE_W-COUNT_W){1'b0}}, limit};
            state_nxt = ST_DIV2;
          end else begin
            div_b     = pref;
            state_nxt = ST_DIV1;
          end
        end else if (accept) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_DIV1: begin
        if (div_done) begin
          div_start = 1'b1;
          div_a     = total_r;
          div_b     = {{(SIZE_W-COUNT_W){1'b0}}, count_nxt};
          state_nxt = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_done) begin
          div_start = 1'b1;
          div_a     = quot;
          div_b     = q_eff;
          state_nxt = ST_DIV3;
        end
      end
      ST_DIV3: begin
        if (div_done) state_nxt = ST_MUL;
      end
      ST_MUL: state_nxt = ST_SUB;
      ST_SUB: begin
        div_start = 1'b1;
        div_a     = total_r - cp_r;
        div_b     = q_eff;
        state_nxt = ST_DIV4;
      end
      ST_DIV4: begin
        if (div_done) state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (!q_full) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      total_r <= in_total_length;
      count_r <= (pref == '0) ? limit : COUNT_W'(1);
      part_r  <= '0;
      extra_r <= '0;
    end
    if (state_r == ST_DIV1 && div_done) count_r <= count_nxt;
    // part rounded down to a multiple of the quantum
    if (state_r == ST_DIV3 && div_done) part_r <= part_prod[SIZE_W-1:0];
    if (state_r == ST_MUL) cp_r <= cp_prod[SIZE_W-1:0];
    if (state_r == ST_DIV4 && div_done) extra_r <= quot[COUNT_W-1:0];
  end

  assign push              = (state_r == ST_PUSH) && !q_full;
  assign push_desc.total   = total_r;
  assign push_desc.count   = count_r;
  assign push_desc.part    = part_r;
  assign push_desc.quantum = q_eff;
  assign push_desc.extra   = extra_r;

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != '0) && (count_r <= COUNT_W'(PART_LIMIT)))
    else $error("job pushed with bad chunk count");
endmodule

// ===== rtl/qwp_fifo.sv =====
`timescale 1ns / 1ps
module qwp_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  qwp_pkg::job_desc_t push_desc,
  output logic               full,
  input  logic               pop,
  output qwp_pkg::job_desc_t pop_desc,
  output logic               empty
);
  import qwp_pkg::*;

  job_desc_t  mem [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_desc = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue underflow");
endmodule

// ===== rtl/qwp_back.sv =====
`timescale 1ns / 1ps
module qwp_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  qwp_pkg::job_desc_t         desc,
  input  logic                       q_empty,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [qwp_pkg::SIZE_W-1:0] out_chunk_start,
  output logic [qwp_pkg::SIZE_W-1:0] out_chunk_length,
  output logic                       out_final_chunk
);
  import qwp_pkg::*;

  logic              busy_r;
  job_desc_t         d_r;
  logic [IDX_W-1:0]  k_r;
  logic [SIZE_W-1:0] start_r;
  logic              out_valid_r;
  logic [SIZE_W-1:0] ostart_r, olen_r;
  logic              ofinal_r;

  logic              slot_free;
  logic              is_last;
  logic [SIZE_W-1:0] len;

  assign slot_free = !out_valid_r || !out_stall;
  assign is_last   = ({1'b0, k_r} == (d_r.count - COUNT_W'(1)));
  assign pop       = !busy_r && !q_empty;

  // leading chunks take one extra quantum, the last one takes the rest
  always_comb begin
    if (is_last) len = d_r.total - start_r;
    else if ({1'b0, k_r} < d_r.extra) len = d_r.part + d_r.quantum;
    else len = d_r.part;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (slot_free) begin
        out_valid_r <= busy_r;
        if (busy_r) begin
          ostart_r <= start_r;
          olen_r   <= len;
          ofinal_r <= is_last;
          start_r  <= start_r + len;
          k_r      <= k_r + IDX_W'(1);
          if (is_last) busy_r <= 1'b0;
        end
      end
      if (pop) begin
        d_r     <= desc;
        k_r     <= '0;
        start_r <= '0;
        busy_r  <= 1'b1;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chunk_start  = ostart_r;
  assign out_chunk_length = olen_r;
  assign out_final_chunk  = ofinal_r;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ({1'b0, k_r} < d_r.count)) else $error("chunk index past count");
  a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && slot_free && is_last) |=> !busy_r || $past(pop))
    else $error("emitter kept running after final chunk");
endmodule
